/* rtl/aes_pkg.sv */
`timescale 1ns / 1ps
package aes_pkg;
   localparam int MAX_ROUNDS = 14;
   localparam int KEY_WORDS = 4 * (MAX_ROUNDS + 1);

   localparam logic [2:0] CSR_KEY_SIZE = 3'd0;
   localparam logic [2:0] CSR_KEY_0 = 3'd1;
   localparam logic [2:0] CSR_KEY_1 = 3'd2;
   localparam logic [2:0] CSR_KEY_2 = 3'd3;
   localparam logic [2:0] CSR_KEY_3 = 3'd4;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [63:0] block_hi;
      logic [63:0] block_lo;
   } req_type_type;

   typedef struct packed {
      logic [63:0] result_hi;
      logic [63:0] result_lo;
   } rsp_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] word_subst(input logic [31:0] w);
      word_subst = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   function automatic logic [127:0] byte_subst(input logic [127:0] s, input logic inv);
      logic [127:0] r;
      for (int i = 0; i < 16; i++) begin
         r[8*i +: 8] = inv ? INV_SBOX[s[8*i +: 8]] : SBOX[s[8*i +: 8]];
      end
      byte_subst = r;
   endfunction

   // byte i of block at bits 127-8i
   function automatic logic [127:0] row_rotate(input logic [127:0] s, input logic inv);
      logic [127:0] r;
      for (int c = 0; c < 4; c++) begin
         for (int rw = 0; rw < 4; rw++) begin
            if (inv) begin
               r[127 - 8*(((c + rw) % 4)*4 + rw) -: 8] = s[127 - 8*(c*4 + rw) -: 8];
            end else begin
               r[127 - 8*(c*4 + rw) -: 8] = s[127 - 8*(((c + rw) % 4)*4 + rw) -: 8];
            end
         end
      end
      row_rotate = r;
   endfunction

   function automatic logic [127:0] column_mix(input logic [127:0] s, input logic inv);
      logic [127:0] r;
      logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3, u, v;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127 - 32*c -: 8];
         a1 = s[119 - 32*c -: 8];
         a2 = s[111 - 32*c -: 8];
         a3 = s[103 - 32*c -: 8];
         if (inv) begin
            u = xtime(xtime(a0 ^ a2));
            v = xtime(xtime(a1 ^ a3));
            a0 = a0 ^ u;
            a1 = a1 ^ v;
            a2 = a2 ^ u;
            a3 = a3 ^ v;
         end
         x0 = xtime(a0);
         x1 = xtime(a1);
         x2 = xtime(a2);
         x3 = xtime(a3);
         r[127 - 32*c -: 8] = x0 ^ x1 ^ a1 ^ a2 ^ a3;
         r[119 - 32*c -: 8] = a0 ^ x1 ^ x2 ^ a2 ^ a3;
         r[111 - 32*c -: 8] = a0 ^ a1 ^ x2 ^ x3 ^ a3;
         r[103 - 32*c -: 8] = x0 ^ a0 ^ a1 ^ a2 ^ x3;
      end
      column_mix = r;
   endfunction
endpackage

/* rtl/aes_block_cipher.sv */
`timescale 1ns / 1ps
// AES-128/192/256 block cipher, one 128-bit block per item, encrypt or decrypt.
// After any key or key-size write, the next item first expands the round-key
// schedule into a 15-row store of 128-bit round keys, one 32-bit word per cycle
// (44, 52 or 60 words), and then fetches the first round key. A block then goes
// through the initial key addition, one round per cycle and the result port,
// where the result waits until it is taken, and the block is ready again the
// cycle after the result is taken. The single round unit reads one round key
// row a cycle from the store. No new item is taken until the result has been
// taken.
module aes_block_cipher
   import aes_pkg::*;
#(
   parameter int ROUNDS_MAX = MAX_ROUNDS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_wdata
);
   localparam int ROWS = ROUNDS_MAX + 1;
   localparam int RW = $clog2(ROWS);
   localparam int WW = RW + 2;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXP  = 3'd1;
   localparam logic [2:0] ST_LOAD = 3'd2;
   localparam logic [2:0] ST_KEY0 = 3'd3;
   localparam logic [2:0] ST_RND  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [1:0]    ksize_ff;
   logic [63:0]   key_ff [4];
   logic          sched_ok_ff, sched_ok_in;
   logic [WW-1:0] widx_ff, widx_in;
   logic [2:0]    kpos_ff, kpos_in;
   logic [7:0]    rc_ff, rc_in;
   logic [31:0]   w1_ff [8];
   logic [31:0]   w1_in [8];
   logic [3:0]    nr_ff, nr_in;
   logic          dec_ff, dec_in;
   logic [127:0]  st_ff, st_in;
   logic [3:0]    rnd_ff, rnd_in;
   logic [127:0]  krow_ff;

   logic [127:0]  kmem [ROWS];
   logic          kwe;
   logic [31:0]   kwdata;
   logic          krd;
   logic [RW-1:0] kraddr;

   logic [1:0]    code;
   logic [3:0]    nk;
   logic [2:0]    nk_last;
   logic [3:0]    nr_new;
   logic [3:0]    next_rnd;
   logic          last_rnd;
   logic [31:0]   t, nw;
   logic [127:0]  rnd_out;

   assign code = (ksize_ff == 2'd3) ? 2'd2 : ksize_ff;
   assign nk = 4'd4 + {1'b0, code, 1'b0};
   assign nk_last = {code + 2'd1, 1'b1};
   assign nr_new = nk + 4'd6;
   assign next_rnd = dec_ff ? rnd_ff - 4'd1 : rnd_ff + 4'd1;
   assign last_rnd = dec_ff ? (rnd_ff == 4'd0) : (rnd_ff == nr_ff);
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data = st_ff;

   // next schedule word, w1_ff[j] holds word i-1-j
   always_comb begin
      t = w1_ff[0];
      if (kpos_ff == 3'd0) begin
         t = word_subst({t[23:0], t[31:24]}) ^ {rc_ff, 24'h0};
      end else if (code == 2'd2 && kpos_ff == 3'd4) begin
         t = word_subst(t);
      end
      nw = w1_ff[nk_last] ^ t;
   end

   // one full round on the state
   always_comb begin
      logic [127:0] a;
      a = row_rotate(st_ff, dec_ff);
      a = byte_subst(a, dec_ff);
      if (!dec_ff) begin
         if (!last_rnd) a = column_mix(a, 1'b0);
         a = a ^ krow_ff;
      end else begin
         a = a ^ krow_ff;
         if (!last_rnd) a = column_mix(a, 1'b1);
      end
      rnd_out = a;
   end

   always_ff @(posedge clock) begin
      if (kwe) kmem[widx_ff[WW-1:2]][{~widx_ff[1:0], 5'd0} +: 32] <= kwdata;
      if (krd) krow_ff <= kmem[kraddr];
   end

   always_comb begin
      state_in = state_ff;
      sched_ok_in = sched_ok_ff;
      widx_in = widx_ff;
      kpos_in = kpos_ff;
      rc_in = rc_ff;
      w1_in = w1_ff;
      nr_in = nr_ff;
      dec_in = dec_ff;
      st_in = st_ff;
      rnd_in = rnd_ff;
      kwe = 1'b0;
      kwdata = nw;
      krd = 1'b0;
      kraddr = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dec_in = req_data.req_type;
               st_in = {req_data.block_hi, req_data.block_lo};
               nr_in = nr_new;
               rnd_in = (req_data.req_type == OP_DECRYPT) ? nr_new - 4'd1 : 4'd1;
               widx_in = '0;
               kpos_in = '0;
               rc_in = 8'h01;
               if (sched_ok_ff) begin
                  krd = 1'b1;
                  kraddr = RW'((req_data.req_type == OP_DECRYPT) ? nr_new : 4'd0);
                  state_in = ST_KEY0;
               end else begin
                  state_in = ST_EXP;
               end
            end
         end
         ST_EXP: begin
            kwe = 1'b1;
            if (widx_ff < WW'(nk)) begin
               kwdata = widx_ff[0] ? key_ff[widx_ff[2:1]][31:0]
                                   : key_ff[widx_ff[2:1]][63:32];
            end else if (kpos_ff == 3'd0) begin
               rc_in = xtime(rc_ff);
            end
            for (int j = 7; j > 0; j--) w1_in[j] = w1_ff[j-1];
            w1_in[0] = kwdata;
            kpos_in = (kpos_ff == nk_last) ? 3'd0 : kpos_ff + 3'd1;
            widx_in = widx_ff + WW'(1);
            if (widx_ff == WW'({nr_ff, 2'b11})) begin
               sched_ok_in = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            krd = 1'b1;
            kraddr = RW'(dec_ff ? nr_ff : 4'd0);
            state_in = ST_KEY0;
         end
         ST_KEY0: begin
            st_in = st_ff ^ krow_ff;
            krd = 1'b1;
            kraddr = RW'(rnd_ff);
            state_in = ST_RND;
         end
         ST_RND: begin
            st_in = rnd_out;
            if (last_rnd) begin
               state_in = ST_OUT;
            end else begin
               krd = 1'b1;
               kraddr = RW'(next_rnd);
               rnd_in = next_rnd;
            end
         end
         ST_OUT: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (csr_we && csr_index <= CSR_KEY_3) sched_ok_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ksize_ff <= '0;
         key_ff[0] <= '0;
         key_ff[1] <= '0;
         key_ff[2] <= '0;
         key_ff[3] <= '0;
         sched_ok_ff <= 1'b0;
         widx_ff <= '0;
         kpos_ff <= '0;
         rc_ff <= 8'h01;
         w1_ff <= '{default: '0};
         nr_ff <= 4'd10;
         dec_ff <= 1'b0;
         st_ff <= '0;
         rnd_ff <= '0;
      end else begin
         state_ff <= state_in;
         sched_ok_ff <= sched_ok_in;
         widx_ff <= widx_in;
         kpos_ff <= kpos_in;
         rc_ff <= rc_in;
         w1_ff <= w1_in;
         nr_ff <= nr_in;
         dec_ff <= dec_in;
         st_ff <= st_in;
         rnd_ff <= rnd_in;
         if (csr_we && csr_index == CSR_KEY_SIZE) ksize_ff <= csr_wdata[1:0];
         if (csr_we && csr_index >= CSR_KEY_0 && csr_index <= CSR_KEY_3) begin
            key_ff[2'(csr_index - CSR_KEY_0)] <= csr_wdata;
         end
      end
   end
endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
   import aes_pkg::*;

   localparam logic [2:0] CSR_UNUSED_FIRST = 3'd5;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 138;
   localparam int SETTLE_CYCLES = 100;

   typedef struct {
      logic [1:0]   key_size;
      logic [255:0] key;
      logic         op;
      logic [127:0] block;
      bit           known;
      logic [127:0] result;
   } vector_row_type;

   localparam logic [255:0] KEY_SEQ = {128'h000102030405060708090a0b0c0d0e0f,
                                       128'h101112131415161718191a1b1c1d1e1f};
   localparam logic [255:0] KEY_ONES = {256{1'b1}};
   localparam logic [127:0] PT_FIPS = 128'h00112233445566778899aabbccddeeff;
   localparam logic [127:0] CT_128 = 128'h69c4e0d86a7b0430d8cdb78070b4c55a;
   localparam logic [127:0] CT_192 = 128'hdda97ca4864cdfe06eaf70a0ec0d7191;
   localparam logic [127:0] CT_256 = 128'h8ea2b7ca516745bfeafc49904b496089;

   vector_row_type vector_rows [15] = '{
      '{2'd0, {KEY_SEQ[255:128], 128'h0}, OP_ENCRYPT, PT_FIPS, 1, CT_128},
      '{2'd0, {KEY_SEQ[255:128], 128'h0}, OP_DECRYPT, CT_128, 1, PT_FIPS},
      '{2'd1, {KEY_SEQ[255:64], 64'h0}, OP_ENCRYPT, PT_FIPS, 1, CT_192},
      '{2'd1, {KEY_SEQ[255:64], 64'h0}, OP_DECRYPT, CT_192, 1, PT_FIPS},
      '{2'd2, KEY_SEQ, OP_ENCRYPT, PT_FIPS, 1, CT_256},
      '{2'd2, KEY_SEQ, OP_DECRYPT, CT_256, 1, PT_FIPS},
      '{2'd3, KEY_SEQ, OP_ENCRYPT, PT_FIPS, 1, CT_256},
      '{2'd0, 256'h0, OP_ENCRYPT, 128'h0, 1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
      '{2'd0, 256'h0, OP_DECRYPT, 128'h0, 0, 128'h0},
      '{2'd0, KEY_ONES, OP_ENCRYPT, {128{1'b1}}, 0, 128'h0},
      '{2'd0, KEY_ONES, OP_DECRYPT, {128{1'b1}}, 0, 128'h0},
      '{2'd2, KEY_ONES, OP_ENCRYPT, 128'h0, 0, 128'h0},
      '{2'd1, KEY_ONES, OP_DECRYPT, {128{1'b1}}, 0, 128'h0},
      '{2'd2, 256'h0, OP_ENCRYPT, {128{1'b1}}, 0, 128'h0},
      '{2'd0, KEY_SEQ, OP_ENCRYPT, {16{8'ha5}}, 0, 128'h0}
   };

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_type_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_type      rsp_data;
   logic         csr_we;
   logic [2:0]   csr_index;
   logic [63:0]  csr_wdata;

   logic [7:0]  fwd_sub [256];
   logic [7:0]  rev_sub [256];
   logic [1:0]  key_size_reg;
   logic [63:0] key_reg [4];
   logic [31:0] round_words [60];
   int          round_count;

   rsp_type     block_expect_q [$];
   int          error_count;
   int          items_sent;
   int          blocks_checked;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          hold_request;
   int          hold_served;
   int          hold_left;

   aes_block_cipher u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("testbench: errors");
      $finish;
   end

   function automatic logic [7:0] gf_double(logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p = p ^ a;
         a = gf_double(a);
      end
      return p;
   endfunction

   function automatic logic [7:0] gf_inverse(logic [7:0] x);
      logic [7:0] r;
      logic [7:0] b;
      r = 8'h01;
      b = x;
      for (int e = 254; e != 0; e = e >> 1) begin
         if (e & 1) r = gf_mul(r, b);
         b = gf_mul(b, b);
      end
      return r;
   endfunction

   function automatic void build_sub_tables();
      logic [7:0] b;
      logic [7:0] s;
      for (int x = 0; x < 256; x++) begin
         b = gf_inverse(x[7:0]);
         s = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]} ^ {b[3:0], b[7:4]} ^ 8'h63;
         fwd_sub[x] = s;
         rev_sub[s] = x[7:0];
      end
   endfunction

   function automatic logic [31:0] subst_word(logic [31:0] w);
      return {fwd_sub[w[31:24]], fwd_sub[w[23:16]], fwd_sub[w[15:8]], fwd_sub[w[7:0]]};
   endfunction

   function automatic void expand_key_schedule();
      int code;
      int nk;
      int total;
      logic [31:0] t;
      logic [7:0] rcon;
      code = (key_size_reg == 2'd3) ? 2 : int'(key_size_reg);
      nk = 4 + 2 * code;
      round_count = nk + 6;
      total = 4 * (round_count + 1);
      rcon = 8'h01;
      for (int i = 0; i < nk; i++) begin
         round_words[i] = (i % 2) ? key_reg[i / 2][31:0] : key_reg[i / 2][63:32];
      end
      for (int i = nk; i < total; i++) begin
         t = round_words[i - 1];
         if (i % nk == 0) begin
            t = subst_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
            rcon = gf_double(rcon);
         end else if (nk > 6 && i % nk == 4) begin
            t = subst_word(t);
         end
         round_words[i] = round_words[i - nk] ^ t;
      end
   endfunction

   function automatic logic [127:0] add_round(logic [127:0] v, int rnd);
      return v ^ {round_words[4*rnd], round_words[4*rnd+1], round_words[4*rnd+2],
                  round_words[4*rnd+3]};
   endfunction

   function automatic logic [127:0] sub_state(logic [127:0] v, logic inv);
      logic [127:0] r;
      for (int i = 0; i < 16; i++) begin
         r[127-8*i -: 8] = inv ? rev_sub[v[127-8*i -: 8]] : fwd_sub[v[127-8*i -: 8]];
      end
      return r;
   endfunction

   function automatic logic [127:0] rotate_rows(logic [127:0] v, logic inv);
      logic [127:0] r;
      for (int c = 0; c < 4; c++) begin
         for (int w = 0; w < 4; w++) begin
            if (inv) begin
               r[127-8*(((c+w)%4)*4+w) -: 8] = v[127-8*(c*4+w) -: 8];
            end else begin
               r[127-8*(c*4+w) -: 8] = v[127-8*(((c+w)%4)*4+w) -: 8];
            end
         end
      end
      return r;
   endfunction

   function automatic logic [127:0] mix_state(logic [127:0] v, logic inv);
      logic [7:0] fwd_coef [4];
      logic [7:0] inv_coef [4];
      logic [7:0] n;
      logic [127:0] r;
      fwd_coef = '{8'h02, 8'h03, 8'h01, 8'h01};
      inv_coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
      for (int c = 0; c < 4; c++) begin
         for (int w = 0; w < 4; w++) begin
            n = 8'h00;
            for (int k = 0; k < 4; k++) begin
               n = n ^ gf_mul(inv ? inv_coef[(k+4-w)%4] : fwd_coef[(k+4-w)%4],
                              v[127-8*(c*4+k) -: 8]);
            end
            r[127-8*(c*4+w) -: 8] = n;
         end
      end
      return r;
   endfunction

   function automatic logic [127:0] cipher_block(logic op, logic [127:0] blk);
      logic [127:0] v;
      v = blk;
      if (op == OP_ENCRYPT) begin
         v = add_round(v, 0);
         for (int i = 1; i < round_count; i++) begin
            v = add_round(mix_state(rotate_rows(sub_state(v, 0), 0), 0), i);
         end
         v = add_round(rotate_rows(sub_state(v, 0), 0), round_count);
      end else begin
         v = add_round(v, round_count);
         for (int i = round_count - 1; i > 0; i--) begin
            v = mix_state(add_round(sub_state(rotate_rows(v, 1), 1), i), 1);
         end
         v = add_round(sub_state(rotate_rows(v, 1), 1), 0);
      end
      return v;
   endfunction

   task automatic csr_write(logic [2:0] idx, logic [63:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == CSR_KEY_SIZE) begin
         key_size_reg = val[1:0];
      end else if (idx <= CSR_KEY_3) begin
         key_reg[2'(idx - CSR_KEY_0)] = val;
      end
   endtask

   task automatic load_key(logic [63:0] size_word, logic [255:0] key, bit with_unused);
      int first;
      logic [2:0] idx;
      req_valid <= 1'b0;
      wait (block_expect_q.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      first = $urandom_range(4);
      for (int i = 0; i < 5; i++) begin
         idx = 3'((first + i) % 5);
         if (idx == CSR_KEY_SIZE) csr_write(idx, size_word);
         else csr_write(idx, key[255 - 64*(idx - CSR_KEY_0) -: 64]);
      end
      if (with_unused) csr_write(3'($urandom_range(CSR_UNUSED_FIRST, 7)), {$urandom, $urandom});
      csr_we <= 1'b0;
      expand_key_schedule();
   endtask

   task automatic send_block(logic op, logic [127:0] blk);
      rsp_type want;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= '{req_type: op, block_hi: blk[127:64], block_lo: blk[63:0]};
      want = cipher_block(op, blk);
      do @(posedge clock); while (!req_ready);
      block_expect_q.push_back(want);
      items_sent++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (block_expect_q.size() == 0) begin
               $error("result with no item outstanding: %h", rsp_data);
               error_count++;
            end else begin
               want = block_expect_q.pop_front();
               blocks_checked++;
               if (rsp_data.result_hi !== want.result_hi) begin
                  $error("result_hi expected %h actual %h", want.result_hi, rsp_data.result_hi);
                  error_count++;
               end
               if (rsp_data.result_lo !== want.result_lo) begin
                  $error("result_lo expected %h actual %h", want.result_lo, rsp_data.result_lo);
                  error_count++;
               end
            end
         end
         if (hold_left == 0 && hold_request != hold_served) begin
            hold_served = hold_request;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      logic [255:0] key;
      logic [63:0] size_word;
      logic [127:0] blk;
      logic [127:0] want;
      int mode;
      build_sub_tables();
      error_count = 0;
      items_sent = 0;
      blocks_checked = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_request = 0;
      hold_served = 0;
      hold_left = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_KEY_SIZE;
      csr_wdata <= '0;
      key_size_reg = 2'd0;
      for (int i = 0; i < 4; i++) key_reg[i] = 64'h0;
      expand_key_schedule();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // known-answer and corner blocks
      for (int r = 0; r < $size(vector_rows); r++) begin
         if (r == 0 || vector_rows[r].key_size != key_size_reg ||
             vector_rows[r].key != {key_reg[0], key_reg[1], key_reg[2], key_reg[3]}) begin
            load_key({62'h0, vector_rows[r].key_size}, vector_rows[r].key, r == 0);
         end
         want = cipher_block(vector_rows[r].op, vector_rows[r].block);
         if (vector_rows[r].known && want !== vector_rows[r].result) begin
            $error("known answer row %0d expected %h predicted %h", r,
                   vector_rows[r].result, want);
            error_count++;
         end
         send_block(vector_rows[r].op, vector_rows[r].block);
      end

      for (int p = 0; p < PHASES; p++) begin
         size_word = {$urandom, $urandom};
         if (p < 4) size_word[1:0] = 2'(p);
         if (p == 1) key = '0;
         else if (p == 2) key = KEY_ONES;
         else key = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom};
         load_key(size_word, key, 1);
         mode = p % 4;
         send_idle_pct = (mode == 1) ? 82 : (mode == 3) ? 34 : 0;
         recv_stall_pct = (mode == 2) ? 82 : (mode == 3) ? 34 : 0;
         if (p == 4) hold_request++;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(15) == 0) blk = {128{$urandom_range(1) == 1}};
            else blk = {$urandom, $urandom, $urandom, $urandom};
            send_block($urandom_range(1), blk);
         end
      end
      req_valid <= 1'b0;
      wait (block_expect_q.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("sent %0d blocks, checked %0d results over all key sizes,", items_sent,
               blocks_checked);
      $display("both directions, with sender gaps, receiver stalls and a long hold-off");
      if (error_count == 0 && block_expect_q.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end
endmodule

/* aes_block_cipher.f */
rtl/aes_pkg.sv
rtl/aes_block_cipher.sv
dv/testbench.sv
